>>> rtl/tmbp_pkg.sv
// Shared constants, types and register codes for the trimmed-mean PWM block.
`default_nettype none

package tmbp_pkg;

   // Sample and window sizing
   localparam int SAMPLE_BITS = 12;
   localparam int MAX_WINDOW  = 32;
   localparam int MIN_WINDOW  = 3;
   localparam int COUNT_BITS  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int DEN_BITS    = $clog2(MAX_WINDOW - 1);
   localparam int STEP_BITS   = $clog2(SUM_BITS + 1);

   // Configuration register widths and reset values
   localparam int CFG_COUNT_BITS = 6;
   localparam int PERIOD_BITS    = 12;
   localparam int CSR_DATA_BITS  = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CFG_COUNT_BITS-1:0] COUNT_RESET  = CFG_COUNT_BITS'(10);
   localparam logic [PERIOD_BITS-1:0]    PERIOD_RESET = PERIOD_BITS'(512);

   // Result field widths
   localparam int FILT_BITS  = 12;
   localparam int DUTY_BITS  = 7;
   localparam int CMP_BITS   = 13;
   localparam int BAR_BITS   = 6;
   localparam int LEVEL_BITS = 3;
   localparam int LED_LEVELS = 6;

   // Constant dividers as reciprocal multiplies: floor(x * R / 2^S)
   // mean / 40 over the full quotient; a cut window can push the mean past 12 bits
   localparam int DUTY_FULL_BITS  = 12;
   localparam int DUTY_RECIP      = 104858;
   localparam int DUTY_RECIP_BITS = 17;
   localparam int DUTY_SHIFT      = 22;
   localparam int DUTY_PROD_BITS  = SUM_BITS + DUTY_RECIP_BITS;
   // mean / 700, only needed below the first dark level
   localparam int LEVEL_STEP       = 700;
   localparam int LEVEL_LIMIT      = LED_LEVELS * LEVEL_STEP;
   localparam int LEVEL_IN_BITS    = 13;
   localparam int LEVEL_RECIP      = 1498;
   localparam int LEVEL_RECIP_BITS = 11;
   localparam int LEVEL_SHIFT      = 20;
   localparam int LEVEL_PROD_BITS  = LEVEL_IN_BITS + LEVEL_RECIP_BITS;
   // (period * duty) / 100
   localparam int PROD_BITS      = PERIOD_BITS + DUTY_FULL_BITS;
   localparam int CMP_RECIP      = 21474837;
   localparam int CMP_RECIP_BITS = 25;
   localparam int CMP_SHIFT      = 31;
   localparam int CMP_PROD_BITS  = PROD_BITS + CMP_RECIP_BITS;

   // Register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SAMPLE_COUNT = 2'd0,
      REG_PWM_PERIOD   = 2'd1
   } reg_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_SCALE,
      ST_CMP_MUL,
      ST_OUT
   } state_type;

   // Accumulator control and status
   typedef struct packed {
      logic take;
      logic clear;
   } acc_ctrl_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]  count;
      logic [SUM_BITS-1:0]    sum;
      logic [SAMPLE_BITS-1:0] min;
      logic [SAMPLE_BITS-1:0] max;
   } acc_stat_type;

   // Divider control and status
   typedef struct packed {
      logic                start;
      logic [SUM_BITS-1:0] dividend;
      logic [DEN_BITS-1:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [SUM_BITS-1:0] quotient;
   } div_stat_type;

endpackage

`default_nettype wire

>>> rtl/tmbp_if.sv
// Request and response channel interfaces for the trimmed-mean PWM block.
`default_nettype none

interface tmbp_req_if;
   logic                             valid;
   logic                             ready;
   logic [tmbp_pkg::SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tmbp_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tmbp_pkg::FILT_BITS-1:0]  filtered_value;
   logic [tmbp_pkg::DUTY_BITS-1:0]  duty_percent;
   logic [tmbp_pkg::CMP_BITS-1:0]   pwm_compare;
   logic [tmbp_pkg::BAR_BITS-1:0]   led_bar;

   modport source (output valid, output filtered_value, output duty_percent,
                   output pwm_compare, output led_bar, input ready);
   modport sink   (input valid, input filtered_value, input duty_percent,
                   input pwm_compare, input led_bar, output ready);
endinterface

`default_nettype wire

>>> rtl/tmbp_accum.sv
// Window accumulator: running sum, minimum, maximum and sample count.
`default_nettype none

module tmbp_accum (
   input  wire                              clock,
   input  wire                              reset,
   input  tmbp_pkg::acc_ctrl_type           ctrl,
   input  wire [tmbp_pkg::SAMPLE_BITS-1:0]  sample,
   output tmbp_pkg::acc_stat_type           stat
);

   logic [tmbp_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [tmbp_pkg::SUM_BITS-1:0]    sum_ff, sum_in;
   logic [tmbp_pkg::SAMPLE_BITS-1:0] min_ff, min_in;
   logic [tmbp_pkg::SAMPLE_BITS-1:0] max_ff, max_in;

   // Next window state
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (ctrl.clear) begin
         count_in = '0;
         sum_in   = '0;
         min_in   = '1;
         max_in   = '0;
      end else if (ctrl.take) begin
         count_in = count_ff + tmbp_pkg::COUNT_BITS'(1);
         sum_in   = sum_ff + tmbp_pkg::SUM_BITS'(sample);
         if (sample < min_ff) min_in = sample;
         if (sample > max_ff) max_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '1;
         max_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

   assign stat.count = count_ff;
   assign stat.sum   = sum_ff;
   assign stat.min   = min_ff;
   assign stat.max   = max_ff;

endmodule

`default_nettype wire

>>> rtl/tmbp_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tmbp_div (
   input  wire                     clock,
   input  wire                     reset,
   input  tmbp_pkg::div_ctrl_type  ctrl,
   output tmbp_pkg::div_stat_type  stat
);

   logic [tmbp_pkg::DEN_BITS-1:0]  rem_ff, rem_in;
   logic [tmbp_pkg::SUM_BITS-1:0]  quo_ff, quo_in;
   logic [tmbp_pkg::DEN_BITS-1:0]  den_ff, den_in;
   logic [tmbp_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [tmbp_pkg::DEN_BITS:0]    shifted;
   logic [tmbp_pkg::DEN_BITS:0]    diff;
   logic                           fits;

   // One trial subtraction per step
   assign shifted = {rem_ff, quo_ff[tmbp_pkg::SUM_BITS-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = ctrl.dividend;
         den_in  = ctrl.divisor;
         step_in = tmbp_pkg::STEP_BITS'(tmbp_pkg::SUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[tmbp_pkg::DEN_BITS-1:0] : shifted[tmbp_pkg::DEN_BITS-1:0];
         quo_in  = {quo_ff[tmbp_pkg::SUM_BITS-2:0], fits};
         step_in = step_ff - tmbp_pkg::STEP_BITS'(1);
         if (step_ff == tmbp_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/trimmed_mean_bar_pwm.sv
// A sample that does not close a window passes through accept (idle) and count check.
// A window-closing sample then goes through the divider, by the window length less two,
// then scale, compare multiply and output; the output state waits for a free response slot.
// A new sample is taken only in idle, after the previous one is through.
// Reset (synchronous): sample_count 10, pwm_period 512, empty window, no response.
// Top level: trimmed-mean filter with PWM duty, compare value and LED bar.
`default_nettype none

module trimmed_mean_bar_pwm (
   input  wire                                 clock,
   input  wire                                 reset,
   tmbp_req_if.sink                            req_ch,
   tmbp_rsp_if.source                          rsp_ch,
   input  wire                                 csr_we,
   input  wire [tmbp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire [tmbp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   // Configuration registers
   logic [tmbp_pkg::CFG_COUNT_BITS-1:0] sample_count_ff;
   logic [tmbp_pkg::PERIOD_BITS-1:0]    pwm_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= tmbp_pkg::COUNT_RESET;
         pwm_period_ff   <= tmbp_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tmbp_pkg::REG_SAMPLE_COUNT:
               sample_count_ff <= csr_wdata[tmbp_pkg::CFG_COUNT_BITS-1:0];
            tmbp_pkg::REG_PWM_PERIOD:
               pwm_period_ff <= csr_wdata[tmbp_pkg::PERIOD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Effective window length, clamped to MIN_WINDOW..MAX_WINDOW
   logic [tmbp_pkg::COUNT_BITS-1:0] n_eff;

   always_comb begin
      if (sample_count_ff < tmbp_pkg::CFG_COUNT_BITS'(tmbp_pkg::MIN_WINDOW)) begin
         n_eff = tmbp_pkg::COUNT_BITS'(tmbp_pkg::MIN_WINDOW);
      end else if (32'(sample_count_ff) > 32'(tmbp_pkg::MAX_WINDOW)) begin
         n_eff = tmbp_pkg::COUNT_BITS'(tmbp_pkg::MAX_WINDOW);
      end else begin
         n_eff = tmbp_pkg::COUNT_BITS'(sample_count_ff);
      end
   end

   // Sub-units
   tmbp_pkg::acc_ctrl_type acc_ctrl;
   tmbp_pkg::acc_stat_type acc_stat;
   tmbp_pkg::div_ctrl_type div_ctrl;
   tmbp_pkg::div_stat_type div_stat;

   tmbp_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (acc_ctrl),
      .sample (req_ch.sample),
      .stat   (acc_stat)
   );

   tmbp_div u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   // Sequencer and datapath registers
   tmbp_pkg::state_type                 state_ff, state_in;
   logic [tmbp_pkg::COUNT_BITS-1:0]     n_ff;
   logic [tmbp_pkg::FILT_BITS-1:0]      mean_ff;
   logic [tmbp_pkg::DUTY_FULL_BITS-1:0] duty_ff;
   logic [tmbp_pkg::BAR_BITS-1:0]       bar_ff;
   logic [tmbp_pkg::PROD_BITS-1:0]      prod_ff;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tmbp_pkg::FILT_BITS-1:0]      rsp_filt_ff;
   logic [tmbp_pkg::DUTY_BITS-1:0]      rsp_duty_ff;
   logic [tmbp_pkg::CMP_BITS-1:0]       rsp_cmp_ff;
   logic [tmbp_pkg::BAR_BITS-1:0]       rsp_bar_ff;

   logic take_req;
   logic load_scale;
   logic load_prod;
   logic load_rsp;

   // Scaling arithmetic
   logic [tmbp_pkg::FILT_BITS-1:0]       mean_q;
   logic [tmbp_pkg::DUTY_PROD_BITS-1:0]  duty_prod;
   logic [tmbp_pkg::LEVEL_PROD_BITS-1:0] level_prod;
   logic [tmbp_pkg::LEVEL_BITS-1:0]      level;
   logic                                 level_ok;
   logic [tmbp_pkg::BAR_BITS-1:0]        bar;
   logic [tmbp_pkg::CMP_PROD_BITS-1:0]   cmp_prod;

   // Duty and the level range check work on the full quotient; the filtered field is cut
   assign mean_q     = div_stat.quotient[tmbp_pkg::FILT_BITS-1:0];
   assign duty_prod  = tmbp_pkg::DUTY_PROD_BITS'(div_stat.quotient)
                     * tmbp_pkg::DUTY_PROD_BITS'(tmbp_pkg::DUTY_RECIP);
   assign level_ok   = (div_stat.quotient < tmbp_pkg::SUM_BITS'(tmbp_pkg::LEVEL_LIMIT));
   assign level_prod = tmbp_pkg::LEVEL_PROD_BITS'(div_stat.quotient[tmbp_pkg::LEVEL_IN_BITS-1:0])
                     * tmbp_pkg::LEVEL_PROD_BITS'(tmbp_pkg::LEVEL_RECIP);
   assign level      = level_prod[tmbp_pkg::LEVEL_SHIFT +: tmbp_pkg::LEVEL_BITS];
   assign cmp_prod   = tmbp_pkg::CMP_PROD_BITS'(prod_ff)
                     * tmbp_pkg::CMP_PROD_BITS'(tmbp_pkg::CMP_RECIP);

   // Thermometer bar: LEDs 0..level lit, dark when level is out of range
   always_comb begin
      for (int i = 0; i < tmbp_pkg::BAR_BITS; i++) begin
         bar[i] = level_ok && (i <= 32'(level));
      end
   end

   // Next state and controls
   always_comb begin
      state_in       = state_ff;
      acc_ctrl.take  = 1'b0;
      acc_ctrl.clear = 1'b0;
      div_ctrl.start = 1'b0;
      // Trimmed numerator and divisor for the divider
      div_ctrl.dividend = acc_stat.sum
                        - tmbp_pkg::SUM_BITS'(acc_stat.min)
                        - tmbp_pkg::SUM_BITS'(acc_stat.max);
      div_ctrl.divisor  = tmbp_pkg::DEN_BITS'(n_ff - tmbp_pkg::COUNT_BITS'(2));
      take_req       = 1'b0;
      load_scale     = 1'b0;
      load_prod      = 1'b0;
      load_rsp       = 1'b0;
      unique case (state_ff)
         tmbp_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               take_req      = 1'b1;
               acc_ctrl.take = 1'b1;
               state_in      = tmbp_pkg::ST_CHECK;
            end
         end
         tmbp_pkg::ST_CHECK: begin
            if (acc_stat.count >= n_ff) begin
               div_ctrl.start = 1'b1;
               acc_ctrl.clear = 1'b1;
               state_in       = tmbp_pkg::ST_DIV;
            end else begin
               state_in = tmbp_pkg::ST_IDLE;
            end
         end
         tmbp_pkg::ST_DIV: begin
            if (div_stat.done) state_in = tmbp_pkg::ST_SCALE;
         end
         tmbp_pkg::ST_SCALE: begin
            load_scale = 1'b1;
            state_in   = tmbp_pkg::ST_CMP_MUL;
         end
         tmbp_pkg::ST_CMP_MUL: begin
            load_prod = 1'b1;
            state_in  = tmbp_pkg::ST_OUT;
         end
         tmbp_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = tmbp_pkg::ST_IDLE;
            end
         end
         default: state_in = tmbp_pkg::ST_IDLE;
      endcase
   end

   // Response valid: set on load, dropped once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmbp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take_req) n_ff <= n_eff;
      if (load_scale) begin
         mean_ff <= mean_q;
         duty_ff <= duty_prod[tmbp_pkg::DUTY_SHIFT +: tmbp_pkg::DUTY_FULL_BITS];
         bar_ff  <= bar;
      end
      if (load_prod) begin
         prod_ff <= tmbp_pkg::PROD_BITS'(pwm_period_ff) * tmbp_pkg::PROD_BITS'(duty_ff);
      end
      if (load_rsp) begin
         rsp_filt_ff <= mean_ff;
         rsp_duty_ff <= duty_ff[tmbp_pkg::DUTY_BITS-1:0];
         rsp_cmp_ff  <= cmp_prod[tmbp_pkg::CMP_SHIFT +: tmbp_pkg::CMP_BITS];
         rsp_bar_ff  <= bar_ff;
      end
   end

   assign req_ch.ready          = (state_ff == tmbp_pkg::ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.filtered_value = rsp_filt_ff;
   assign rsp_ch.duty_percent   = rsp_duty_ff;
   assign rsp_ch.pwm_compare    = rsp_cmp_ff;
   assign rsp_ch.led_bar        = rsp_bar_ff;

   // Divider only finishes while the sequencer waits on it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == tmbp_pkg::ST_DIV))
      else $error("divider finished outside divide state");

   // Window count never runs past the largest window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      acc_stat.count <= tmbp_pkg::COUNT_BITS'(tmbp_pkg::MAX_WINDOW))
      else $error("window count past maximum");

   // Closing a window leaves the accumulator empty
   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmbp_pkg::ST_CHECK && state_in == tmbp_pkg::ST_DIV)
      |=> (acc_stat.count == '0 && acc_stat.sum == '0))
      else $error("window not cleared at close");

   // A stalled response keeps its valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready)
      |=> (rsp_valid_ff && $stable(rsp_filt_ff) && $stable(rsp_duty_ff)
           && $stable(rsp_cmp_ff) && $stable(rsp_bar_ff)))
      else $error("stalled response changed");

endmodule

`default_nettype wire
